/* rtl/pstb_pkg.sv */
// Shared types and constants for the periodic soft timer bank.
// No dependencies; used by pstb_engine and the top level.
package pstb_pkg;

  // Timer count; one bit per timer in the 16-bit masks.
  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned TIMER_AW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CD_W     = 18;   // signed countdown, -11 .. 65534
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned ENTRY_W  = PERIOD_W + CD_W;
  localparam int unsigned AMT_W    = 4;

  localparam int unsigned TICK_SHORT_MS = 1;
  localparam int unsigned TICK_LONG_MS  = 10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK1  = 3'd0,
    FUNC_TICK10 = 3'd1,
    FUNC_ENABLE = 3'd2,
    FUNC_STOP   = 3'd3,
    FUNC_RESUME = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_TICK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic [MASK_W-1:0] run_mask;
  } res_t;

endpackage

/* rtl/pstb_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pstb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pstb_engine.sv */
// Command sequencer and shared countdown datapath over the timer RAM.
// Depends on pstb_pkg and pstb_ram.
module pstb_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  logic [pstb_pkg::FUNC_W-1:0]    func_i,
  input  logic [pstb_pkg::INDEX_W-1:0]   timer_index_i,
  input  logic [pstb_pkg::PERIOD_W-1:0]  period_ms_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output pstb_pkg::res_t                 res_o
);

  localparam int unsigned N  = pstb_pkg::NUM_TIMERS;
  localparam int unsigned AW = pstb_pkg::TIMER_AW;
  localparam int unsigned CW = pstb_pkg::CD_W;
  localparam int unsigned PW = pstb_pkg::PERIOD_W;
  localparam int unsigned EW = pstb_pkg::ENTRY_W;
  localparam int unsigned MW = pstb_pkg::MASK_W;

  pstb_pkg::state_e state_q, state_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic             wb_vld_q, wb_vld_d;
  logic [AW-1:0]    wb_idx_q, wb_idx_d;
  logic [pstb_pkg::AMT_W-1:0] amt_q, amt_d;
  logic [N-1:0]     fire_q, fire_d;
  logic [N-1:0]     run_q, run_d;
  logic [N-1:0]     ent_vld_q, ent_vld_d;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic             re;
  logic [EW-1:0]    rdata;

  logic             accept;
  logic             idx_ok;
  logic [5:0]       idx_ext;
  logic [AW-1:0]    idx_addr;
  logic [PW-1:0]    cur_period;
  logic signed [CW-1:0] cur_cd;
  logic signed [CW-1:0] dec_cd;
  logic signed [CW-1:0] reload_cd;
  logic signed [CW-1:0] enable_cd;

  pstb_ram #(
    .Width (EW),
    .Depth (N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign cmd_ready_o = (state_q == pstb_pkg::ST_IDLE);
  assign res_valid_o = (state_q == pstb_pkg::ST_DONE);
  assign accept      = cmd_valid_i && cmd_ready_o;

  assign idx_ext  = {2'b00, timer_index_i};
  assign idx_ok   = (idx_ext < 6'(N));
  assign idx_addr = idx_ext[AW-1:0];

  // Entries never written read as zero.
  assign cur_period = ent_vld_q[wb_idx_q] ? rdata[EW-1 -: PW] : '0;
  assign cur_cd     = ent_vld_q[wb_idx_q] ? $signed(rdata[CW-1:0]) : '0;
  assign dec_cd     = cur_cd - $signed({{(CW-pstb_pkg::AMT_W){1'b0}}, amt_q});
  assign reload_cd  = $signed({{(CW-PW){1'b0}}, cur_period}) - 18'sd1;
  assign enable_cd  = $signed({{(CW-PW){1'b0}}, period_ms_i}) - 18'sd1;

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    wb_vld_d  = 1'b0;
    wb_idx_d  = wb_idx_q;
    amt_d     = amt_q;
    fire_d    = fire_q;
    run_d     = run_q;
    ent_vld_d = ent_vld_q;
    we        = 1'b0;
    waddr     = idx_addr;
    wdata     = {period_ms_i, enable_cd};
    re        = 1'b0;

    case (state_q)
      pstb_pkg::ST_IDLE: begin
        if (accept) begin
          fire_d = '0;
          ptr_d  = '0;
          case (pstb_pkg::func_e'(func_i))
            pstb_pkg::FUNC_TICK1: begin
              amt_d   = pstb_pkg::AMT_W'(pstb_pkg::TICK_SHORT_MS);
              state_d = pstb_pkg::ST_TICK;
            end
            pstb_pkg::FUNC_TICK10: begin
              amt_d   = pstb_pkg::AMT_W'(pstb_pkg::TICK_LONG_MS);
              state_d = pstb_pkg::ST_TICK;
            end
            pstb_pkg::FUNC_ENABLE: begin
              if (idx_ok) begin
                we                  = 1'b1;
                ent_vld_d[idx_addr] = 1'b1;
                run_d[idx_addr]     = 1'b1;
              end
              state_d = pstb_pkg::ST_DONE;
            end
            pstb_pkg::FUNC_STOP: begin
              if (idx_ok) begin
                run_d[idx_addr] = 1'b0;
              end
              state_d = pstb_pkg::ST_DONE;
            end
            pstb_pkg::FUNC_RESUME: begin
              if (idx_ok) begin
                run_d[idx_addr] = 1'b1;
              end
              state_d = pstb_pkg::ST_DONE;
            end
            default: begin
              state_d = pstb_pkg::ST_DONE;
            end
          endcase
        end
      end
      pstb_pkg::ST_TICK: begin
        re       = 1'b1;
        wb_vld_d = 1'b1;
        wb_idx_d = ptr_q;
        if (ptr_q == AW'(N - 1)) begin
          state_d = pstb_pkg::ST_DRAIN;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      pstb_pkg::ST_DRAIN: begin
        state_d = pstb_pkg::ST_DONE;
      end
      pstb_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = pstb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pstb_pkg::ST_IDLE;
      end
    endcase

    // Write-back of the entry read last cycle; reads run one entry ahead.
    if (wb_vld_q && run_q[wb_idx_q]) begin
      we                  = 1'b1;
      waddr               = wb_idx_q;
      ent_vld_d[wb_idx_q] = 1'b1;
      if (dec_cd[CW-1]) begin
        fire_d[wb_idx_q] = 1'b1;
        wdata            = {cur_period, reload_cd};
      end else begin
        wdata            = {cur_period, dec_cd};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pstb_pkg::ST_IDLE;
      ptr_q     <= '0;
      wb_vld_q  <= 1'b0;
      wb_idx_q  <= '0;
      amt_q     <= '0;
      fire_q    <= '0;
      run_q     <= '0;
      ent_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      wb_vld_q  <= wb_vld_d;
      wb_idx_q  <= wb_idx_d;
      amt_q     <= amt_d;
      fire_q    <= fire_d;
      run_q     <= run_d;
      ent_vld_q <= ent_vld_d;
    end
  end

  // Only the low timers show in the masks.
  logic [MW-1:0] fire_m;
  logic [MW-1:0] run_m;

  for (genvar i = 0; i < MW; i++) begin : g_mask
    if (i < N) begin : g_on
      assign fire_m[i] = fire_q[i];
      assign run_m[i]  = run_q[i];
    end else begin : g_off
      assign fire_m[i] = 1'b0;
      assign run_m[i]  = 1'b0;
    end
  end

  assign res_o.fire_mask = fire_m;
  assign res_o.run_mask  = run_m;

endmodule

/* rtl/periodic_soft_timer_bank.sv */
// Top level of the periodic soft timer bank: command sequencer plus output register.
// Depends on pstb_pkg and pstb_engine.
//
// A bank of periodic millisecond timers driven by command items on a valid/ready
// channel; every item yields exactly one result item (fire mask and run mask).
// func 0/1 ticks 1 ms or 10 ms; 2 enables a timer with period_ms (countdown
// loads with period - 1); 3 stops; 4 resumes without touching the countdown;
// codes 5..7 change nothing. Enable, stop, resume and unknown codes go from
// accept straight to the result state. For a tick, the period and countdown
// of every timer sit in one RAM with a single registered read port, and one
// shared decrementer walks the timers one per cycle, reading entry k while
// writing back entry k - 1. Stopped timers are skipped on write.
// A countdown that falls below zero sets its fire bit and reloads to
// period - 1; overshoot on a 10 ms tick is dropped. Results sit in an output
// register, so the next item is accepted while a result waits to be taken.
// Reset clears all state at once through per-entry valid bits; no clearing pass.
module periodic_soft_timer_bank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pstb_pkg::FUNC_W-1:0]    func_i,
  input  logic [pstb_pkg::INDEX_W-1:0]   timer_index_i,
  input  logic [pstb_pkg::PERIOD_W-1:0]  period_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pstb_pkg::MASK_W-1:0]    fire_mask_o,
  output logic [pstb_pkg::MASK_W-1:0]    run_mask_o
);

  logic           res_valid;
  logic           res_ready;
  pstb_pkg::res_t res;

  pstb_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (in_valid_i),
    .cmd_ready_o   (in_ready_o),
    .func_i        (func_i),
    .timer_index_i (timer_index_i),
    .period_ms_i   (period_ms_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: frees the engine as soon as a result is handed over.
  logic                          out_vld_q, out_vld_d;
  logic [pstb_pkg::MASK_W-1:0]   fire_q, fire_d;
  logic [pstb_pkg::MASK_W-1:0]   run_q, run_d;

  assign res_ready = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    fire_d    = fire_q;
    run_d     = run_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
      fire_d    = res.fire_mask;
      run_d     = res.run_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fire_q <= fire_d;
    run_q  <= run_d;
  end

  assign out_valid_o = out_vld_q;
  assign fire_mask_o = fire_q;
  assign run_mask_o  = run_q;

`ifndef SYNTHESIS
  // A command that is not a tick finishes in the cycle after accept.
  a_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && func_i != pstb_pkg::FUNC_TICK1
      && func_i != pstb_pkg::FUNC_TICK10) |=> res_valid)
    else $error("non-tick command did not complete in one cycle");

  // A finished result never coexists with a new accept.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ready_o)
    else $error("item accepted while a result is pending in the engine");

  // A handed-over result lands in the output register unchanged.
  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=>
      (out_valid_o && fire_mask_o == $past(res.fire_mask)
        && run_mask_o == $past(res.run_mask)))
    else $error("result lost or corrupted at output register");
`endif

endmodule
